// ----- rtl/fixed_radius_neighbor_search_top_defines.svh -----
// ----------------------------------------------------------------------------
// Fixed radius neighbor search - assertion macros
// Shared property wrappers; clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef FIXED_RADIUS_NEIGHBOR_SEARCH_TOP_DEFINES_SVH
`define FIXED_RADIUS_NEIGHBOR_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication
`define FRNS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FRNS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/frns_pkg.sv -----
// ----------------------------------------------------------------------------
// Fixed radius neighbor search - package
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package frns_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 24;

    localparam int POS_W     = 24;  // coordinate port width
    localparam int IDX_W     = 6;   // query / neighbor index width
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int RAD_W     = 23;  // radius register width
    localparam int RSQ_W     = 2 * RAD_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNLOADED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGNMENT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COHESION   = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic clear;       // empty the table
        logic append;      // store one point
        logic query;       // query accepted: read query point, reset scan
        logic load_q;      // capture query point from RAM
        logic scan;        // walk the table
        logic emit_final;  // write last result of a loaded query
        logic emit_miss;   // write "index not loaded" result
    } frns_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic q_loaded;    // query index below point count
        logic scan_last;   // scan pointer at last stored point
        logic adv;         // pipeline advances this cycle
        logic pipe_empty;  // no entry in flight
        logic out_free;    // output register can take a result
    } frns_sts_t;

endpackage

// ----- rtl/frns_ram.sv -----
// ----------------------------------------------------------------------------
// Fixed radius neighbor search - generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module frns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/frns_ctrl.sv -----
// ----------------------------------------------------------------------------
// Fixed radius neighbor search - controller
// Sequences table updates and the query scan; drives datapath commands.
// ----------------------------------------------------------------------------
module frns_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic [frns_pkg::MODE_W-1:0] s_mode,
    output logic                       s_ready,
    input  frns_pkg::frns_sts_t        sts,
    output frns_pkg::frns_cmd_t        cmd
);
    import frns_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_QRD   = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_DONE  = 6'b010000,
        ST_MISS  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_mode == MODE_CLEAR) begin
                        cmd.clear = 1'b1;
                    end else if (s_mode == MODE_APPEND) begin
                        cmd.append = 1'b1;
                    end else if (s_mode == MODE_QUERY) begin
                        if (sts.q_loaded) begin
                            cmd.query  = 1'b1;
                            state_next = ST_QRD;
                        end else begin
                            state_next = ST_MISS;
                        end
                    end
                end
            end
            ST_QRD: begin
                cmd.load_q = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.adv && sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (sts.pipe_empty) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.emit_final = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_MISS: begin
                if (sts.out_free) begin
                    cmd.emit_miss = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/frns_datapath.sv -----
// ----------------------------------------------------------------------------
// Fixed radius neighbor search - datapath
// Point table, radius registers, distance pipeline, pending hit and output.
// ----------------------------------------------------------------------------
module frns_datapath #(
    parameter int MAX_POINTS = frns_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = frns_pkg::COORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  frns_pkg::frns_cmd_t                 cmd,
    output frns_pkg::frns_sts_t                 sts,
    input  logic signed [frns_pkg::POS_W-1:0]   pos_x,
    input  logic signed [frns_pkg::POS_W-1:0]   pos_y,
    input  logic signed [frns_pkg::POS_W-1:0]   pos_z,
    input  logic [frns_pkg::IDX_W-1:0]          query_index,
    input  logic                                cfg_wr_en,
    input  logic [frns_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [frns_pkg::RAD_W-1:0]          cfg_wr_data,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [frns_pkg::IDX_W-1:0]          m_neighbor_index,
    output logic [frns_pkg::STATUS_W-1:0]       m_status,
    output logic                                m_last
);
    import frns_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int PT_W  = 3 * C;
    localparam int SQ_W  = 2 * C;
    localparam int SUM_W = 2 * C + 2;
    localparam int CMP_W = (SUM_W > RSQ_W) ? SUM_W : RSQ_W;
    localparam int QC_W  = (IDX_W > CNT_W) ? IDX_W : CNT_W;

    // radius registers and squared maximum
    logic [RAD_W-1:0] sep_reg, ali_reg, coh_reg;
    logic [RAD_W-1:0] rmax_reg, rmax_next;
    logic [RSQ_W-1:0] rsq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_reg  <= '0;
            ali_reg  <= '0;
            coh_reg  <= '0;
            rmax_reg <= '0;
            rsq_reg  <= '0;
        end else begin
            if (cfg_wr_en && (cfg_index == CFG_SEPARATION)) sep_reg <= cfg_wr_data;
            if (cfg_wr_en && (cfg_index == CFG_ALIGNMENT))  ali_reg <= cfg_wr_data;
            if (cfg_wr_en && (cfg_index == CFG_COHESION))   coh_reg <= cfg_wr_data;
            rmax_reg <= rmax_next;
            rsq_reg  <= RSQ_W'(rmax_reg) * RSQ_W'(rmax_reg);
        end
    end

    always_comb begin
        rmax_next = sep_reg;
        if (ali_reg > rmax_next) rmax_next = ali_reg;
        if (coh_reg > rmax_next) rmax_next = coh_reg;
    end

    // point table
    logic [CNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]    j_reg, j_next;
    logic [AW-1:0]    q_idx_reg;
    logic             wr_en, rd_en, issue, adv;
    logic [AW-1:0]    rd_addr;
    logic [PT_W-1:0]  wr_data, rd_data;

    assign wr_en   = cmd.append && (count_reg < CNT_W'(MAX_POINTS));
    assign wr_data = {C'(pos_z), C'(pos_y), C'(pos_x)};
    assign issue   = cmd.scan && adv;
    assign rd_en   = cmd.query || issue;
    assign rd_addr = cmd.query ? query_index[AW-1:0] : j_reg;

    frns_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        count_next = count_reg;
        if (cmd.clear) begin
            count_next = '0;
        end else if (wr_en) begin
            count_next = count_reg + CNT_W'(1);
        end
        j_next = j_reg;
        if (cmd.query) begin
            j_next = '0;
        end else if (issue) begin
            j_next = j_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        j_reg <= j_next;
        if (cmd.query) begin
            q_idx_reg <= query_index[AW-1:0];
        end
    end

    // distance pipeline: p0 (RAM read) -> s1 |d| -> s2 d^2 -> s3 sum
    logic signed [C-1:0] rd_axis [3];
    logic signed [C-1:0] q_pt_reg [3];
    logic signed [C:0]   diff [3];
    logic [C-1:0]        mag_next [3];
    logic [C-1:0]        s1_mag_reg [3];
    logic [SQ_W-1:0]     s2_sq_reg [3];
    logic [SUM_W-1:0]    s3_sum_reg;
    logic                p0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [AW-1:0]       p0_idx_reg, s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic                hit;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rd_axis[k]  = rd_data[k*C +: C];
            diff[k]     = (C+1)'(rd_axis[k]) - (C+1)'(q_pt_reg[k]);
            mag_next[k] = diff[k][C] ? C'(-diff[k]) : C'(diff[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_q) begin
            for (int k = 0; k < 3; k++) begin
                q_pt_reg[k] <= rd_axis[k];
            end
        end
        if (adv) begin
            if (issue) p0_idx_reg <= j_reg;
            s1_idx_reg <= p0_idx_reg;
            s2_idx_reg <= s1_idx_reg;
            s3_idx_reg <= s2_idx_reg;
            for (int k = 0; k < 3; k++) begin
                s1_mag_reg[k] <= mag_next[k];
                s2_sq_reg[k]  <= SQ_W'(s1_mag_reg[k]) * SQ_W'(s1_mag_reg[k]);
            end
            s3_sum_reg <= SUM_W'(s2_sq_reg[0]) + SUM_W'(s2_sq_reg[1])
                        + SUM_W'(s2_sq_reg[2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            // the query point itself is skipped
            p0_valid_reg <= issue && (j_reg != q_idx_reg);
            s1_valid_reg <= p0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    assign hit = s3_valid_reg && (CMP_W'(s3_sum_reg) < CMP_W'(rsq_reg));

    // pending hit: held until the next hit or end of scan sets its last flag
    logic             pend_valid_reg, pend_valid_next;
    logic [AW-1:0]    pend_idx_reg, pend_idx_next;
    logic             out_free;

    logic                m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]    m_idx_reg, m_idx_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic                m_last_reg, m_last_next;
    logic                out_load;

    assign out_free = !m_valid_reg || m_ready;
    assign adv      = !(hit && pend_valid_reg && !out_free);

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        if (cmd.query || cmd.emit_final) begin
            pend_valid_next = 1'b0;
        end else if (hit && adv) begin
            pend_valid_next = 1'b1;
            pend_idx_next   = s3_idx_reg;
        end
    end

    always_comb begin
        out_load      = 1'b0;
        m_idx_next    = m_idx_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        if (hit && adv && pend_valid_reg) begin
            out_load      = 1'b1;
            m_idx_next    = IDX_W'(pend_idx_reg);
            m_status_next = STATUS_FOUND;
            m_last_next   = 1'b0;
        end else if (cmd.emit_final) begin
            out_load      = 1'b1;
            m_idx_next    = pend_valid_reg ? IDX_W'(pend_idx_reg) : '0;
            m_status_next = pend_valid_reg ? STATUS_FOUND : STATUS_NONE;
            m_last_next   = 1'b1;
        end else if (cmd.emit_miss) begin
            out_load      = 1'b1;
            m_idx_next    = '0;
            m_status_next = STATUS_UNLOADED;
            m_last_next   = 1'b1;
        end
        m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg <= pend_idx_next;
        m_idx_reg    <= m_idx_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_neighbor_index = m_idx_reg;
    assign m_status         = m_status_reg;
    assign m_last           = m_last_reg;

    assign sts.q_loaded   = QC_W'(query_index) < QC_W'(count_reg);
    assign sts.scan_last  = CNT_W'(j_reg) == (count_reg - CNT_W'(1));
    assign sts.adv        = adv;
    assign sts.pipe_empty = !(p0_valid_reg || s1_valid_reg || s2_valid_reg || s3_valid_reg);
    assign sts.out_free   = out_free;

endmodule

// ----- rtl/fixed_radius_neighbor_search_top.sv -----
// ----------------------------------------------------------------------------
// Fixed radius neighbor search - top level
// Brute-force 3D near-neighbor search over a loaded point table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): mode 0 clears the table, mode 1 appends (pos_x/y/z),
//   mode 2 queries the neighbors of stored point query_index; mode 3 is dropped.
//   Clear and append give no result.
//   Result channel (m_*): one transfer per neighbor in ascending index order,
//   last set on the final one. A query with no neighbor returns status 1, a
//   query of an index not loaded returns status 2; both single, with last.
//   Query sequence: accept, read the query point, scan each stored point through
//   the single point RAM read port, drain the distance pipeline and write the
//   final result. The read port sets the rate: one point per cycle while the scan
//   runs. A neighbor is held one step so its last flag is known; if the receiver
//   stalls with a result waiting, the scan freezes until the transfer.
//   Config: cfg_wr_en writes one radius per cycle; the user writes only while the
//   block idles; the block itself does not enforce this.
//   Reset clears point count, radii and handshake state; table contents are
//   left as is, since entries at or above the count are never read.
// ----------------------------------------------------------------------------
`include "fixed_radius_neighbor_search_top_defines.svh"

module fixed_radius_neighbor_search_top #(
    parameter int MAX_POINTS = frns_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = frns_pkg::COORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [frns_pkg::MODE_W-1:0]         s_mode,
    input  logic signed [frns_pkg::POS_W-1:0]   s_pos_x,
    input  logic signed [frns_pkg::POS_W-1:0]   s_pos_y,
    input  logic signed [frns_pkg::POS_W-1:0]   s_pos_z,
    input  logic [frns_pkg::IDX_W-1:0]          s_query_index,
    // radius registers
    input  logic                                cfg_wr_en,
    input  logic [frns_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [frns_pkg::RAD_W-1:0]          cfg_wr_data,
    // results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [frns_pkg::IDX_W-1:0]          m_neighbor_index,
    output logic [frns_pkg::STATUS_W-1:0]       m_status,
    output logic                                m_last
);
    import frns_pkg::*;

    frns_cmd_t cmd;
    frns_sts_t sts;

    // sequencing: table updates, query start, scan, drain, final result
    frns_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // storage, squared-distance pipeline and output register
    frns_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .pos_x            (s_pos_x),
        .pos_y            (s_pos_y),
        .pos_z            (s_pos_z),
        .query_index      (s_query_index),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_neighbor_index (m_neighbor_index),
        .m_status         (m_status),
        .m_last           (m_last)
    );

    // status results stand alone and carry index zero
    `FRNS_ASSERT_NOW(a_status_single, m_valid && (m_status != STATUS_FOUND), m_last && (m_neighbor_index == '0), "status result without last or with nonzero index")
    // the final result is written only after the pipeline has drained
    `FRNS_ASSERT_NOW(a_final_drained, cmd.emit_final, sts.pipe_empty, "final result written with hits in flight")
    // the scan only freezes on a blocked output register
    `FRNS_ASSERT_NOW(a_stall_cause, !sts.adv, m_valid && !m_ready, "scan stalled with output free")
    // a started query holds off the input channel
    `FRNS_ASSERT_NEXT(a_query_busy, cmd.query, !s_ready, "input accepted during query")

endmodule

// ----- sim/neighbor_search_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neighbor search checker
// Tracks the point table and radii from the item and register ports, works out
// each query's neighbor list and compares result transfers against it in order.
// ----------------------------------------------------------------------------
module neighbor_search_checker #(
    parameter int TABLE_DEPTH = frns_pkg::MAX_POINTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [frns_pkg::MODE_W-1:0]         s_mode,
    input  logic signed [frns_pkg::POS_W-1:0]   s_pos_x,
    input  logic signed [frns_pkg::POS_W-1:0]   s_pos_y,
    input  logic signed [frns_pkg::POS_W-1:0]   s_pos_z,
    input  logic [frns_pkg::IDX_W-1:0]          s_query_index,
    input  logic                                cfg_wr_en,
    input  logic [frns_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [frns_pkg::RAD_W-1:0]          cfg_wr_data,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [frns_pkg::IDX_W-1:0]          m_neighbor_index,
    input  logic [frns_pkg::STATUS_W-1:0]       m_status,
    input  logic                                m_last,
    output int                                  mismatches,
    output int                                  pending,
    output int                                  results_seen
);
    import frns_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]    neighbor;
        logic [STATUS_W-1:0] status;
        logic                last;
    } hit_t;

    hit_t                    expected_hits[$];
    logic signed [POS_W-1:0] table_x [TABLE_DEPTH];
    logic signed [POS_W-1:0] table_y [TABLE_DEPTH];
    logic signed [POS_W-1:0] table_z [TABLE_DEPTH];
    int                      stored;
    logic [RAD_W-1:0]        radius [3];

    initial begin
        mismatches   = 0;
        pending      = 0;
        results_seen = 0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 100) begin
            $display("[%0t] ERROR transfer %0d: %s", $time, results_seen, what);
        end
    endtask

    function automatic hit_t make_hit(input logic [IDX_W-1:0] idx,
                                      input logic [STATUS_W-1:0] status,
                                      input logic last);
        hit_t h;
        h.neighbor = idx;
        h.status   = status;
        h.last     = last;
        return h;
    endfunction

    // append one expected transfer at the tail
    task automatic queue_hit(input hit_t h);
        expected_hits.insert(expected_hits.size(), h);
    endtask

    // exact squared distance, unsigned Q50.0, fits easily in 64 bits
    function automatic longint dist_sq(input int a, input int b);
        longint dx, dy, dz;
        dx = longint'(table_x[a]) - longint'(table_x[b]);
        dy = longint'(table_y[a]) - longint'(table_y[b]);
        dz = longint'(table_z[a]) - longint'(table_z[b]);
        return dx * dx + dy * dy + dz * dz;
    endfunction

    task automatic search_neighbors(input logic [IDX_W-1:0] q);
        logic [RAD_W-1:0]       reach;
        longint                 reach_sq;
        logic [TABLE_DEPTH-1:0] near;
        int                     final_hit;
        reach = radius[CFG_SEPARATION];
        if (radius[CFG_ALIGNMENT] > reach) reach = radius[CFG_ALIGNMENT];
        if (radius[CFG_COHESION] > reach) reach = radius[CFG_COHESION];
        reach_sq  = longint'(reach) * longint'(reach);
        near      = '0;
        final_hit = -1;
        if (int'(q) >= stored) begin
            queue_hit(make_hit('0, STATUS_UNLOADED, 1'b1));
        end else begin
            for (int j = 0; j < stored; j++) begin
                if (j != int'(q) && dist_sq(j, int'(q)) < reach_sq) begin
                    near[j]   = 1'b1;
                    final_hit = j;
                end
            end
            if (final_hit < 0) begin
                queue_hit(make_hit('0, STATUS_NONE, 1'b1));
            end else begin
                for (int j = 0; j <= final_hit; j++) begin
                    if (near[j]) begin
                        queue_hit(make_hit(IDX_W'(j), STATUS_FOUND, j == final_hit));
                    end
                end
            end
        end
    endtask

    always @(posedge aclk) begin : monitor
        hit_t want;
        if (!aresetn) begin
            expected_hits.delete();
            stored = 0;
            for (int i = 0; i < 3; i++) radius[i] = '0;
        end else begin
            // results first: an item accepted on this edge cannot answer yet
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_hits.size() == 0) begin
                    report_mismatch($sformatf("unexpected result index %0d status %0d last %0d",
                                              m_neighbor_index, m_status, m_last));
                end else begin
                    want = expected_hits.pop_front();
                    if (m_neighbor_index !== want.neighbor)
                        report_mismatch($sformatf("neighbor_index got %0d want %0d",
                                                  m_neighbor_index, want.neighbor));
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  m_status, want.status));
                    if (m_last !== want.last)
                        report_mismatch($sformatf("last got %0d want %0d",
                                                  m_last, want.last));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SEPARATION, CFG_ALIGNMENT, CFG_COHESION: begin
                        radius[cfg_index] = cfg_wr_data;
                    end
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_mode)
                    MODE_CLEAR: stored = 0;
                    MODE_APPEND: begin
                        if (stored < TABLE_DEPTH) begin
                            table_x[stored] = s_pos_x;
                            table_y[stored] = s_pos_y;
                            table_z[stored] = s_pos_z;
                            stored++;
                        end
                    end
                    MODE_QUERY: search_neighbors(s_query_index);
                    default: ;
                endcase
            end
        end
        pending <= expected_hits.size();
    end

endmodule

// ----- sim/tb_fixed_radius_neighbor_search_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed radius neighbor search testbench
// Loads point tables, sets radii and fires queries at the block with random
// gaps and backpressure; the checker alongside predicts and compares results.
// ----------------------------------------------------------------------------
module tb_fixed_radius_neighbor_search_top;
    import frns_pkg::*;

    // Slowest plausible run: ~20 phases of (3 reg writes + a settle) plus
    // ~120 queries with a full scan and up to 63 transfers each under 19%
    // stalls, plus 200+ items with short gaps, all well inside the limit.
    localparam int unsigned CYCLE_LIMIT   = 500000;
    // clear/append give no transfer, so wait out a full scan before touching the radii
    localparam int          SETTLE_CYCLES = 80;
    localparam int          ITEM_TARGET   = 200;
    localparam int          IDLE_PERCENT  = 19;

    localparam logic [MODE_W-1:0]       MODE_UNUSED = 2'd3;  // dropped by the block
    localparam logic signed [POS_W-1:0] COORD_MAX   = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] COORD_MIN   = 24'sh800000;
    localparam logic [RAD_W-1:0]        RADIUS_MAX  = 23'h7FFFFF;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [MODE_W-1:0]       s_mode;
    logic signed [POS_W-1:0] s_pos_x;
    logic signed [POS_W-1:0] s_pos_y;
    logic signed [POS_W-1:0] s_pos_z;
    logic [IDX_W-1:0]        s_query_index;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [RAD_W-1:0]        cfg_wr_data;
    logic                    m_valid;
    logic                    m_ready;
    logic [IDX_W-1:0]        m_neighbor_index;
    logic [STATUS_W-1:0]     m_status;
    logic                    m_last;

    int          mismatches;
    int          pending;       // result transfers still owed by the block
    int          results_seen;
    int unsigned cycle_count = 0;

    // stimulus bookkeeping
    logic no_idle = 1'b0;       // set for a stretch of phases: no gaps, no stalls
    int   items_sent   = 0;
    int   queries_sent = 0;
    int   settings     = 0;
    int   loaded       = 0;     // points the table should hold right now

    fixed_radius_neighbor_search_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_pos_z          (s_pos_z),
        .s_query_index    (s_query_index),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_neighbor_index (m_neighbor_index),
        .m_status         (m_status),
        .m_last           (m_last)
    );

    neighbor_search_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_pos_z          (s_pos_z),
        .s_query_index    (s_query_index),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_neighbor_index (m_neighbor_index),
        .m_status         (m_status),
        .m_last           (m_last),
        .mismatches       (mismatches),
        .pending          (pending),
        .results_seen     (results_seen)
    );

    // 2 ns clock
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // watchdog: a hang or a missing transfer ends here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d transfers owed", cycle_count, pending);
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver backpressure: ~19% stall cycles unless in the idle-free stretch
    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // One item transfer. Valid may drop for one idle cycle first; otherwise it
    // stays high from the previous transfer and only the payload moves on.
    task automatic send_item(input logic [MODE_W-1:0] mode,
                             input logic signed [POS_W-1:0] x,
                             input logic signed [POS_W-1:0] y,
                             input logic signed [POS_W-1:0] z,
                             input logic [IDX_W-1:0] qi);
        if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_pos_x       <= x;
        s_pos_y       <= y;
        s_pos_z       <= z;
        s_query_index <= qi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // ignored items (unused mode, append to a full table) are not counted
        case (mode)
            MODE_CLEAR: begin
                loaded = 0;
                items_sent++;
            end
            MODE_APPEND: begin
                if (loaded < MAX_POINTS_DEF) begin
                    loaded++;
                    items_sent++;
                end
            end
            MODE_QUERY: begin
                items_sent++;
                queries_sent++;
            end
            default: ;
        endcase
    endtask

    // position fields are don't-care outside appends: fill them at random
    task automatic append_point(input logic signed [POS_W-1:0] x,
                                input logic signed [POS_W-1:0] y,
                                input logic signed [POS_W-1:0] z);
        send_item(MODE_APPEND, x, y, z, IDX_W'($urandom));
    endtask

    task automatic query_point(input logic [IDX_W-1:0] qi);
        send_item(MODE_QUERY, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom), qi);
    endtask

    task automatic clear_table();
        send_item(MODE_CLEAR, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                  IDX_W'($urandom));
    endtask

    // Drop valid, wait until every owed transfer is in, then let a full scan
    // worth of cycles pass so a trailing item is surely done.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // radii only change with the block idle; all three written back to back
    task automatic set_radii(input logic [RAD_W-1:0] sep,
                             input logic [RAD_W-1:0] ali,
                             input logic [RAD_W-1:0] coh);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_SEPARATION;
        cfg_wr_data <= sep;
        @(posedge aclk);
        cfg_index   <= CFG_ALIGNMENT;
        cfg_wr_data <= ali;
        @(posedge aclk);
        cfg_index   <= CFG_COHESION;
        cfg_wr_data <= coh;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        settings++;
    endtask

    // coordinate within +/- spread of a center, wrapping like the port does
    function automatic logic signed [POS_W-1:0] near_coord(
            input logic signed [POS_W-1:0] center, input int spread);
        int off;
        off = int'($urandom_range(2 * spread, 0)) - spread;
        return center + POS_W'(off);
    endfunction

    // radius on the scale of the cluster, clipped to the register range
    function automatic logic [RAD_W-1:0] pick_radius(input int spread);
        int unsigned r;
        r = $urandom_range(2 * spread, 0);
        return (r > RADIUS_MAX) ? RADIUS_MAX : RAD_W'(r);
    endfunction

    initial begin : stimulus
        int                      phase;
        int                      spread;
        int                      n_points;
        int                      n_queries;
        logic signed [POS_W-1:0] cx, cy, cz;
        logic [RAD_W-1:0]        rad [3];

        s_valid       <= 1'b0;
        s_mode        <= MODE_CLEAR;
        s_pos_x       <= '0;
        s_pos_y       <= '0;
        s_pos_z       <= '0;
        s_query_index <= '0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= CFG_SEPARATION;
        cfg_wr_data   <= '0;
        m_ready       <= 1'b0;
        aresetn       <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // ---------------- directed part ----------------
        // radii are all zero out of reset
        query_point(0);                       // empty table: not loaded
        query_point(63);                      // top index, empty table
        append_point(0, 0, 0);
        append_point(0, 0, 0);                // duplicate point, distance zero
        query_point(0);                       // zero radius: nothing is strictly inside
        send_item(MODE_UNUSED, COORD_MAX, COORD_MIN, COORD_MAX, 6'h3F);  // dropped
        query_point(2);                       // index equal to count: not loaded

        set_radii(1, 0, 0);                   // separation largest, r^2 = 1 LSB
        query_point(0);                       // twin at distance zero is a hit
        query_point(1);

        set_radii(0, 0, RADIUS_MAX);          // cohesion largest, at full scale
        append_point(COORD_MAX, COORD_MAX, COORD_MAX);
        append_point(COORD_MIN, COORD_MIN, COORD_MIN);
        append_point(COORD_MAX, COORD_MIN, 0);
        query_point(0);
        query_point(2);
        query_point(3);
        query_point(4);

        set_radii(5, 23'd4096, 0);            // alignment largest
        query_point(0);
        clear_table();
        query_point(0);                       // cleared table: not loaded

        // ---------------- random part ----------------
        // Each phase: new radii, a cluster of points around a random center
        // at a random scale, then queries, mostly of loaded indexes.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            spread = 1 << $urandom_range(23, 2);
            for (int i = 0; i < 3; i++) rad[i] = pick_radius(spread);
            case ($urandom_range(9))
                0: for (int i = 0; i < 3; i++) rad[i] = '0;
                1: rad[$urandom_range(2, 0)] = RADIUS_MAX;
                default: ;
            endcase
            set_radii(rad[0], rad[1], rad[2]);

            // phases 3 and 4 run with no gaps and no stalls at all
            no_idle = (phase == 3 || phase == 4);

            // phase 1 always overfills the table so appends past the end drop
            if (phase == 1 || loaded == 0 || $urandom_range(3) != 0) clear_table();
            if (phase == 1) n_points = 66;
            else if ($urandom_range(9) == 0) n_points = $urandom_range(70, 60);
            else n_points = $urandom_range(16, 2);

            cx = POS_W'($urandom);
            cy = POS_W'($urandom);
            cz = POS_W'($urandom);
            for (int i = 0; i < n_points; i++) begin
                if ($urandom_range(9) == 0) begin
                    append_point(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
                end else begin
                    append_point(near_coord(cx, spread), near_coord(cy, spread),
                                 near_coord(cz, spread));
                end
                if ($urandom_range(19) == 0) begin
                    send_item(MODE_UNUSED, POS_W'($urandom), POS_W'($urandom),
                              POS_W'($urandom), IDX_W'($urandom));
                end
            end

            n_queries = $urandom_range(8, 3);
            for (int i = 0; i < n_queries; i++) begin
                if (loaded == 0 || $urandom_range(6) == 0) query_point(IDX_W'($urandom));
                else query_point(IDX_W'($urandom_range(loaded - 1, 0)));
            end
            phase++;
        end
        no_idle = 1'b0;

        // drain: everything owed must arrive, then watch a little longer for strays
        settle();

        $display("Run covered %0d items (%0d queries) over %0d radius settings,",
                 items_sent, queries_sent, settings);
        $display("with %0d result transfers checked under random gaps and stalls.",
                 results_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
